@@ hdl/rth_pkg.sv @@
// Shared types, constants and the reciprocal table of the RGB to HSV converter.
`default_nettype none
package rth_pkg;

	localparam int CHAN_W       = 8;
	localparam int HUE_W        = 15;
	localparam int HUE_NUM_W    = 20;
	localparam int SAT_NUM_W    = 16;
	localparam int HUE_Q_W      = 12;
	localparam int REM_W        = 9;
	localparam int RECIP_SHIFT  = 20;
	localparam int RECIP_W      = 21;
	localparam int RECIP_DEPTH  = 256;
	localparam int QUEUE_DEPTH  = 4;
	localparam int S_DATA_W     = 32;
	localparam int M_DATA_W     = 40;

	localparam int HUE_SECTOR   = 3840;
	localparam int HUE_FULL     = 23040;
	localparam int HUE_OFS_GRN  = 7680;
	localparam int HUE_OFS_BLU  = 15360;
	localparam int SAT_SCALE    = 255;

	localparam logic [1:0] SECT_RED = 2'd0;
	localparam logic [1:0] SECT_GRN = 2'd1;
	localparam logic [1:0] SECT_BLU = 2'd2;

	typedef struct packed {
		logic [HUE_NUM_W-1:0] hue_num;
		logic [SAT_NUM_W-1:0] sat_num;
		logic [CHAN_W-1:0]    hue_div;
		logic [CHAN_W-1:0]    mx;
		logic [1:0]           sector;
		logic                 neg;
		logic [CHAN_W-1:0]    alpha;
	} rth_item_t;

	typedef logic [RECIP_W-1:0] recip_lut_t [RECIP_DEPTH];

	function automatic recip_lut_t build_recip();
		recip_lut_t lut;
		lut[0] = '0;
		for (int i = 1; i < RECIP_DEPTH; i++) begin
			lut[i] = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(i));
		end
		return lut;
	endfunction

	// Entry d holds floor(2^20 / d); entry zero is never used for a real quotient.
	localparam recip_lut_t RECIP_LUT = build_recip();

endpackage
`default_nettype wire

@@ hdl/rth_front.sv @@
// Front end: finds max, min and hue sector and forms the two dividends.
`default_nettype none
module rth_front
	import rth_pkg::*;
(
	input  wire logic [CHAN_W-1:0] red,
	input  wire logic [CHAN_W-1:0] green,
	input  wire logic [CHAN_W-1:0] blue,
	input  wire logic [CHAN_W-1:0] alpha,
	output rth_item_t              item
);

	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic [CHAN_W-1:0] d;
	logic [CHAN_W-1:0] p;
	logic [CHAN_W-1:0] q;
	logic [CHAN_W-1:0] diff_abs;
	logic [1:0]        sector;
	logic              neg;

	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		d  = mx - mn;
		if (mx == red) begin
			sector = SECT_RED;
			p      = green;
			q      = blue;
		end else if (mx == green) begin
			sector = SECT_GRN;
			p      = blue;
			q      = red;
		end else begin
			sector = SECT_BLU;
			p      = red;
			q      = green;
		end
		neg      = (p < q);
		diff_abs = neg ? (q - p) : (p - q);
	end

	always_comb begin
		item.hue_num = HUE_NUM_W'(diff_abs) * HUE_NUM_W'(HUE_SECTOR);
		item.sat_num = SAT_NUM_W'(d) * SAT_NUM_W'(SAT_SCALE) + SAT_NUM_W'(mx[CHAN_W-1:1]);
		item.hue_div = d;
		item.mx      = mx;
		item.sector  = sector;
		item.neg     = neg;
		item.alpha   = alpha;
	end

endmodule
`default_nettype wire

@@ hdl/rth_fifo.sv @@
// Short register queue that decouples the front end from the divider pipeline.
`default_nettype none
module rth_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/rth_back.sv @@
// Back end: reciprocal divide with correction, hue assembly and output register.
`default_nettype none
module rth_back
	import rth_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_pop,
	input  wire rth_item_t         in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [HUE_W-1:0]       hue,
	output logic [CHAN_W-1:0]      saturation,
	output logic [CHAN_W-1:0]      brightness,
	output logic [CHAN_W-1:0]      alpha_out
);

	localparam int HUE_PROD_W = HUE_NUM_W + RECIP_W;
	localparam int SAT_PROD_W = SAT_NUM_W + RECIP_W;

	logic                   adv;
	logic                   v_s1;
	logic                   v_s2;
	logic                   v_s3;
	logic                   out_valid_q;
	rth_item_t              item_s1;
	rth_item_t              item_s2;
	rth_item_t              item_s3;
	logic [RECIP_W-1:0]     recip_h_s1;
	logic [RECIP_W-1:0]     recip_s_s1;
	logic [HUE_Q_W-1:0]     q0_h_s2;
	logic [CHAN_W-1:0]      q0_s_s2;
	logic [HUE_Q_W-1:0]     q0_h_s3;
	logic [CHAN_W-1:0]      q0_s_s3;
	logic [REM_W-1:0]       rem_h_s3;
	logic [REM_W-1:0]       rem_s_s3;
	logic [HUE_PROD_W-1:0]  prod_h;
	logic [SAT_PROD_W-1:0]  prod_s;
	logic [HUE_NUM_W-1:0]   rem_h_full;
	logic [SAT_NUM_W-1:0]   rem_s_full;
	logic [HUE_Q_W-1:0]     q_h;
	logic [CHAN_W-1:0]      q_s;
	logic [HUE_W-1:0]       hue_calc;
	logic [HUE_W-1:0]       hue_q;
	logic [CHAN_W-1:0]      sat_q;
	logic [CHAN_W-1:0]      bright_q;
	logic [CHAN_W-1:0]      alpha_q;

	assign adv    = !out_valid_q || out_ready;
	assign in_pop = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_comb begin
		prod_h     = HUE_PROD_W'(item_s1.hue_num) * HUE_PROD_W'(recip_h_s1);
		prod_s     = SAT_PROD_W'(item_s1.sat_num) * SAT_PROD_W'(recip_s_s1);
		rem_h_full = item_s2.hue_num - HUE_NUM_W'(q0_h_s2) * HUE_NUM_W'(item_s2.hue_div);
		rem_s_full = item_s2.sat_num - SAT_NUM_W'(q0_s_s2) * SAT_NUM_W'(item_s2.mx);
	end

	always_comb begin
		q_h = q0_h_s3 + HUE_Q_W'(rem_h_s3 >= REM_W'(item_s3.hue_div));
		q_s = q0_s_s3 + CHAN_W'(rem_s_s3 >= REM_W'(item_s3.mx));
		case (item_s3.sector)
			SECT_RED: begin
				hue_calc = item_s3.neg ? HUE_W'(HUE_FULL) - HUE_W'(q_h) : HUE_W'(q_h);
			end
			SECT_GRN: begin
				hue_calc = item_s3.neg ? HUE_W'(HUE_OFS_GRN) - HUE_W'(q_h)
					: HUE_W'(HUE_OFS_GRN) + HUE_W'(q_h);
			end
			SECT_BLU: begin
				hue_calc = item_s3.neg ? HUE_W'(HUE_OFS_BLU) - HUE_W'(q_h)
					: HUE_W'(HUE_OFS_BLU) + HUE_W'(q_h);
			end
			default: begin
				hue_calc = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= in_item;
			recip_h_s1 <= RECIP_LUT[in_item.hue_div];
			recip_s_s1 <= RECIP_LUT[in_item.mx];

			item_s2    <= item_s1;
			q0_h_s2    <= prod_h[RECIP_SHIFT+HUE_Q_W-1:RECIP_SHIFT];
			q0_s_s2    <= prod_s[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];

			item_s3    <= item_s2;
			q0_h_s3    <= q0_h_s2;
			q0_s_s3    <= q0_s_s2;
			rem_h_s3   <= rem_h_full[REM_W-1:0];
			rem_s_s3   <= rem_s_full[REM_W-1:0];

			hue_q      <= (item_s3.hue_div == '0) ? '0 : hue_calc;
			sat_q      <= (item_s3.mx == '0) ? '0 : q_s;
			bright_q   <= item_s3.mx;
			alpha_q    <= item_s3.alpha;
		end
	end

	assign out_valid  = out_valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;
	assign alpha_out  = alpha_q;

endmodule
`default_nettype wire

@@ hdl/rgb_to_hsv_pixel.sv @@
// Top level of the RGBA to HSVA pixel converter.
//
// The slave stream carries one RGBA pixel per transfer and the master stream one
// HSV pixel with alpha. The front end finds the largest and smallest channel and
// the hue sector at the input transfer and writes the result into a short queue.
// The back end divides by table reciprocal, multiply and one correction step.
// An input pixel is registered in the queue, the back-end pipeline stages and the
// output register in turn. Throughput is one pixel per cycle, set by the back-end
// pipeline that advances whenever its output register is empty or being taken.
// When the receiver stalls, the pipeline holds and the queue fills; s_tready
// drops only when the queue is full. Reset empties the queue and clears all
// valid flags, so no transfer is offered until new pixels arrive. Hue is in
// 1/64 degree units from 0 to 23039 and is 0 for grey pixels.
`default_nettype none
module rgb_to_hsv_pixel
	import rth_pkg::*;
#(
	parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// red [7:0], green [15:8], blue [23:16], alpha [31:24]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// hue [14:0], saturation [22:15], brightness [30:23], alpha_out [38:31], zero [39]
	output logic [M_DATA_W-1:0]      m_tdata
);

	rth_item_t         front_item;
	rth_item_t         queue_item;
	logic              queue_valid;
	logic              queue_pop;
	logic [HUE_W-1:0]  hue;
	logic [CHAN_W-1:0] saturation;
	logic [CHAN_W-1:0] brightness;
	logic [CHAN_W-1:0] alpha_out;

	rth_front u_front (
		.red   (s_tdata[7:0]),
		.green (s_tdata[15:8]),
		.blue  (s_tdata[23:16]),
		.alpha (s_tdata[31:24]),
		.item  (front_item)
	);

	rth_fifo #(
		.WIDTH ($bits(rth_item_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_data  (front_item),
		.rd_valid (queue_valid),
		.rd_en    (queue_pop),
		.rd_data  (queue_item)
	);

	rth_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (queue_valid),
		.in_pop     (queue_pop),
		.in_item    (queue_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.alpha_out  (alpha_out)
	);

	assign m_tdata = {1'b0, alpha_out, brightness, saturation, hue};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hue < HUE_W'(HUE_FULL)))
		else $error("hue out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && saturation == '0) |-> (hue == '0))
		else $error("grey pixel with nonzero hue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && brightness == '0) |-> (saturation == '0))
		else $error("black pixel with nonzero saturation");

endmodule
`default_nettype wire

@@ sim/rgb_to_hsv_pixel_test.sv @@
// Self-checking stream testbench of the RGBA to HSVA pixel converter.
`timescale 1ns / 1ps
module rgb_to_hsv_pixel_test
	import rth_pkg::*;
();

	localparam int NUM_DIRECTED = 20;
	localparam int NUM_RANDOM   = 1630;
	localparam int IDLE_PCT     = 34;
	localparam int STEADY_FIRST = 700;
	localparam int STEADY_LAST  = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
		logic [CHAN_W-1:0] alpha;
	} hsv_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] a;
		logic              fixed;
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
	} stim_row_t;

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 15'd0,     8'd0,   8'd0},
		'{8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 15'd0,     8'd0,   8'd255},
		'{8'hff, 8'h00, 8'h00, 8'h80, 1'b1, 15'd0,     8'd255, 8'd255},
		'{8'h00, 8'hff, 8'h00, 8'h7f, 1'b1, 15'd7680,  8'd255, 8'd255},
		'{8'h00, 8'h00, 8'hff, 8'h01, 1'b1, 15'd15360, 8'd255, 8'd255},
		'{8'h80, 8'h80, 8'h80, 8'hfe, 1'b1, 15'd0,     8'd0,   8'd128},
		'{8'hff, 8'hff, 8'h00, 8'h55, 1'b0, '0, '0, '0},
		'{8'h00, 8'hff, 8'hff, 8'haa, 1'b0, '0, '0, '0},
		'{8'hff, 8'h00, 8'hff, 8'h33, 1'b0, '0, '0, '0},
		'{8'hff, 8'h00, 8'h01, 8'hcc, 1'b0, '0, '0, '0},
		'{8'h01, 8'h00, 8'h00, 8'h0f, 1'b0, '0, '0, '0},
		'{8'hff, 8'hfe, 8'hfe, 8'hf0, 1'b0, '0, '0, '0},
		'{8'h02, 8'h01, 8'h01, 8'h5a, 1'b0, '0, '0, '0},
		'{8'h03, 8'h01, 8'h02, 8'ha5, 1'b0, '0, '0, '0},
		'{8'h0a, 8'h14, 8'hc8, 8'h3c, 1'b0, '0, '0, '0},
		'{8'hc8, 8'hfa, 8'h0a, 8'hc3, 1'b0, '0, '0, '0},
		'{8'h01, 8'h01, 8'h00, 8'h69, 1'b0, '0, '0, '0},
		'{8'h00, 8'h01, 8'h01, 8'h96, 1'b0, '0, '0, '0},
		'{8'hc8, 8'h64, 8'h96, 8'h00, 1'b0, '0, '0, '0},
		'{8'h00, 8'hfe, 8'hff, 8'hff, 1'b0, '0, '0, '0}
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	hsv_t hsv_expected [$];
	bit   no_idle         = 1'b0;
	int   pixels_sent     = 0;
	int   results_checked = 0;
	int   fail_count      = 0;

	rgb_to_hsv_pixel DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic hsv_t predict_hsv(input logic [S_DATA_W-1:0] px);
		int   r;
		int   g;
		int   b;
		int   mx;
		int   mn;
		int   d;
		int   h;
		hsv_t res;
		r = int'(px[7:0]);
		g = int'(px[15:8]);
		b = int'(px[23:16]);
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d = mx - mn;
		h = 0;
		if (d != 0) begin
			if (mx == r) begin
				h = ((g - b) * HUE_SECTOR) / d;
			end else if (mx == g) begin
				h = HUE_OFS_GRN + ((b - r) * HUE_SECTOR) / d;
			end else begin
				h = HUE_OFS_BLU + ((r - g) * HUE_SECTOR) / d;
			end
			if (h < 0) begin
				h += HUE_FULL;
			end
		end
		res.hue   = HUE_W'(h);
		res.sat   = (mx == 0) ? '0 : CHAN_W'((2 * SAT_SCALE * d + mx) / (2 * mx));
		res.val   = CHAN_W'(mx);
		res.alpha = px[31:24];
		return res;
	endfunction

	task automatic send_pixel(input logic [S_DATA_W-1:0] px, input hsv_t want);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		hsv_expected.push_back(want);
		pixels_sent++;
	endtask

	function automatic logic [S_DATA_W-1:0] random_pixel();
		logic [CHAN_W-1:0] ch [3];
		logic [CHAN_W-1:0] v;
		int                k;
		ch[0] = CHAN_W'($urandom);
		ch[1] = CHAN_W'($urandom);
		ch[2] = CHAN_W'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				v = CHAN_W'($urandom);
				ch = '{v, v, v};
			end
			6: begin
				v = CHAN_W'($urandom);
				k = int'($urandom_range(0, 2));
				ch[k] = v;
				ch[(k + 1) % 3] = v;
				ch[(k + 2) % 3] = CHAN_W'($urandom_range(0, v));
			end
			7: begin
				foreach (ch[i]) ch[i] = CHAN_W'($urandom_range(0, 3));
			end
			8: begin
				foreach (ch[i]) begin
					case ($urandom_range(0, 3))
						0: ch[i] = 8'd0;
						1: ch[i] = 8'd1;
						2: ch[i] = 8'd254;
						default: ch[i] = 8'd255;
					endcase
				end
			end
			9: begin
				v = CHAN_W'($urandom_range(1, 255));
				k = int'($urandom_range(0, 2));
				ch = '{v - 8'd1, v - 8'd1, v - 8'd1};
				ch[k] = v;
				ch[(k + 1) % 3] = CHAN_W'($urandom_range(v - 1, v));
			end
			default: ;
		endcase
		return {8'($urandom), ch[2], ch[1], ch[0]};
	endfunction

	always @(posedge clk) begin
		hsv_t want;
		hsv_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[14:0], m_tdata[22:15], m_tdata[30:23], m_tdata[38:31]};
			results_checked++;
			if (m_tdata[39] !== 1'b0) begin
				$error("pad bit: expected 0, actual %b", m_tdata[39]);
				fail_count++;
			end
			if (hsv_expected.size() == 0) begin
				$error("unexpected result transfer: hue %0d", got.hue);
				fail_count++;
			end else begin
				want = hsv_expected.pop_front();
				if (got.hue !== want.hue) begin
					$error("hue: expected %0d, actual %0d", want.hue, got.hue);
					fail_count++;
				end
				if (got.sat !== want.sat) begin
					$error("saturation: expected %0d, actual %0d", want.sat, got.sat);
					fail_count++;
				end
				if (got.val !== want.val) begin
					$error("brightness: expected %0d, actual %0d", want.val, got.val);
					fail_count++;
				end
				if (got.alpha !== want.alpha) begin
					$error("alpha_out: expected %0d, actual %0d", want.alpha, got.alpha);
					fail_count++;
				end
			end
		end
		m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		logic [S_DATA_W-1:0] px;
		hsv_t                want;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) begin
			px = {DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].g, DIRECTED[i].r};
			if (DIRECTED[i].fixed) begin
				want = '{DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].val, DIRECTED[i].a};
			end else begin
				want = predict_hsv(px);
			end
			send_pixel(px, want);
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			no_idle = (n >= STEADY_FIRST) && (n < STEADY_LAST);
			px = random_pixel();
			send_pixel(px, predict_hsv(px));
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;
		while (hsv_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d pixels (%0d directed, %0d random) under random stalls.",
			pixels_sent, NUM_DIRECTED, NUM_RANDOM);
		$display("Compared %0d result transfers against the predicted HSV values.",
			results_checked);
		if (fail_count == 0 && hsv_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/rth_pkg.sv
hdl/rth_front.sv
hdl/rth_fifo.sv
hdl/rth_back.sv
hdl/rgb_to_hsv_pixel.sv
sim/rgb_to_hsv_pixel_test.sv
